>>> rtl/png_scanline_unfilter_rgb8_unit_assert.svh
// assertion macros for the png scanline unfilter unit
`ifndef PNG_SCANLINE_UNFILTER_RGB8_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_RGB8_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PSU_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("psu check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define PSU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("psu check failed: next-cycle rule");

`else

`define PSU_ASSERT_NOW(label, clk, rst_n, pre, post)
`define PSU_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> rtl/psu_pkg.sv
// shared types and constants for the png scanline unfilter unit
package psu_pkg;

    localparam int unsigned PSU_MAX_PIXELS      = 1024;
    localparam int unsigned PSU_BYTES_PER_PIXEL = 3;

    localparam int unsigned ROW_PIXELS_W = 11;
    localparam int unsigned IMAGE_ROWS_W = 16;

    localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RST = 11'd1024;
    localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_RST = 16'd1;

    // register indexes on the config port
    localparam logic REG_ROW_PIXELS = 1'b0;
    localparam logic REG_IMAGE_ROWS = 1'b1;

    // filter type codes
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // colour channels
    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_BLUE = 2'd2;

    typedef struct packed {
        logic [7:0] filter;
        logic [7:0] x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_pred_in;

endpackage

>>> rtl/psu_ram.sv
// generic simple dual-port ram with registered read
module psu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/psu_predict.sv
// filter predictor and byte reconstruction
module psu_predict (
    input  psu_pkg::t_pred_in i_pred,
    output logic [7:0]        o_value,
    output logic              o_bad
);
    import psu_pkg::*;

    logic signed [9:0] p_a;
    logic signed [9:0] p_b;
    logic signed [9:0] p_c;
    logic signed [9:0] d_a;
    logic signed [9:0] d_b;
    logic signed [9:0] d_c;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    // distances of a + b - c to a, b and c
    always_comb begin
        d_a = $signed({2'b00, i_pred.b}) - $signed({2'b00, i_pred.c});
        d_b = $signed({2'b00, i_pred.a}) - $signed({2'b00, i_pred.c});
        d_c = d_a + d_b;
        p_a = (d_a < 0) ? -d_a : d_a;
        p_b = (d_b < 0) ? -d_b : d_b;
        p_c = (d_c < 0) ? -d_c : d_c;
        if (p_a <= p_b && p_a <= p_c) begin
            paeth = i_pred.a;
        end else if (p_b <= p_c) begin
            paeth = i_pred.b;
        end else begin
            paeth = i_pred.c;
        end
    end

    assign avg_sum = {1'b0, i_pred.a} + {1'b0, i_pred.b};

    always_comb begin
        o_bad = 1'b0;
        case (i_pred.filter)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = i_pred.a;
            FILT_UP:    pred = i_pred.b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default: begin
                pred  = '0;
                o_bad = 1'b1;
            end
        endcase
    end

    assign o_value = i_pred.x + pred;
endmodule

>>> rtl/png_scanline_unfilter_rgb8_unit.sv
// top level of the png scanline unfilter unit for 8-bit rgb rows
//
// input channel: one word per cycle of the inflated stream, i_data_byte with
// i_in_valid / o_in_stall. each row is a filter-type word then 3 * row_pixels
// colour words. filter words give no output.
// output channel: one word per colour byte, o_pixel_byte with channel, row end,
// frame end and bad filter flags, o_out_valid / i_out_stall.
// path: an accepted colour word passes the read stage registers, then the
// output register. throughput: one word per cycle while the output is not
// stalled; the rate is set by the prior-row ram, read for one byte while the
// byte ahead of it is written back in the same cycle.
// the left neighbor comes from a three-byte shift register of rebuilt bytes.
// reset: config goes to 1024 pixels and 1 row, the next word is a filter word
// of row 0; the prior-row ram is not cleared (row 0 uses zero in its place).
// stall: a stalled output holds; one more colour word may sit in the ram
// read stage, after that o_in_stall rises on colour words. filter words are
// always taken.
// config: apb-style, row_pixels at 0x0, image_rows at 0x4, written while idle.
`include "png_scanline_unfilter_rgb8_unit_assert.svh"

module png_scanline_unfilter_rgb8_unit #(
    parameter int unsigned MAX_PIXELS = psu_pkg::PSU_MAX_PIXELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // stream in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // pixels out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_byte,
    output logic [1:0]  o_channel,
    output logic        o_row_end,
    output logic        o_frame_end,
    output logic        o_bad_filter
);
    import psu_pkg::*;

    localparam int unsigned ROW_STORE = PSU_BYTES_PER_PIXEL * MAX_PIXELS;
    localparam int unsigned ADDR_W    = $clog2(ROW_STORE);
    localparam int unsigned POS_W     = $clog2(ROW_STORE + 1);
    localparam int unsigned EW        = $clog2(MAX_PIXELS + 1);

    // config registers
    logic [ROW_PIXELS_W-1:0] r_row_pixels;
    logic [IMAGE_ROWS_W-1:0] r_image_rows;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels <= ROW_PIXELS_RST;
            r_image_rows <= IMAGE_ROWS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROW_PIXELS) begin
                r_row_pixels <= pwdata[ROW_PIXELS_W-1:0];
            end else begin
                r_image_rows <= pwdata[IMAGE_ROWS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_IMAGE_ROWS) begin
            prdata = 32'(r_image_rows);
        end else begin
            prdata = 32'(r_row_pixels);
        end
    end

    // effective row width and row count
    logic [EW-1:0]           eff_w;
    logic [POS_W-1:0]        row_bytes;
    logic [IMAGE_ROWS_W-1:0] eff_rows;

    always_comb begin
        if (r_row_pixels == '0) begin
            eff_w = EW'(1);
        end else if (32'(r_row_pixels) > 32'(MAX_PIXELS)) begin
            eff_w = EW'(MAX_PIXELS);
        end else begin
            eff_w = EW'(r_row_pixels);
        end
    end

    assign row_bytes = POS_W'({eff_w, 1'b0}) + POS_W'(eff_w);
    assign eff_rows  = (r_image_rows == '0) ? IMAGE_ROWS_W'(1) : r_image_rows;

    // front end: row position tracking at accept time
    logic [POS_W-1:0]        r_byte_pos;
    logic [POS_W-1:0]        n_byte_pos;
    logic [1:0]              r_ch;
    logic [1:0]              n_ch;
    logic [7:0]              r_filter;
    logic [IMAGE_ROWS_W-1:0] r_row_index;
    logic [IMAGE_ROWS_W-1:0] n_row_index;
    logic                    in_acc;
    logic                    pix_acc;
    logic                    filt_acc;
    logic                    at_filter;
    logic                    row_last;
    logic                    frame_last;
    logic                    s1_adv;

    // read stage
    logic               r_s1_valid;
    logic [7:0]         r_s1_x;
    logic [7:0]         r_s1_filter;
    logic [1:0]         r_s1_ch;
    logic               r_s1_rend;
    logic               r_s1_fend;
    logic               r_s1_row0;
    logic               r_s1_first;
    logic [ADDR_W-1:0]  r_s1_addr;

    assign at_filter = (r_byte_pos == '0);
    assign o_in_stall = !at_filter && r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pix_acc    = in_acc && !at_filter;
    assign filt_acc   = in_acc && at_filter;

    assign row_last   = (r_byte_pos >= row_bytes);
    assign frame_last = ({1'b0, r_row_index} + (IMAGE_ROWS_W + 1)'(1)) >= {1'b0, eff_rows};

    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_ch        = r_ch;
        n_row_index = r_row_index;
        if (filt_acc) begin
            n_byte_pos = POS_W'(1);
            n_ch       = CH_RED;
        end else if (pix_acc) begin
            if (row_last) begin
                n_byte_pos  = '0;
                n_ch        = CH_RED;
                n_row_index = frame_last ? '0 : r_row_index + IMAGE_ROWS_W'(1);
            end else begin
                n_byte_pos = r_byte_pos + POS_W'(1);
                n_ch       = (r_ch == CH_BLUE) ? CH_RED : r_ch + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_ch        <= CH_RED;
            r_row_index <= '0;
            r_filter    <= FILT_NONE;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_ch        <= n_ch;
            r_row_index <= n_row_index;
            if (filt_acc) begin
                r_filter <= i_data_byte;
            end
        end
    end

    // read stage registers, loaded alongside the ram read
    logic [ADDR_W-1:0] rd_addr;

    assign rd_addr = ADDR_W'(r_byte_pos - POS_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_x      <= i_data_byte;
            r_s1_filter <= r_filter;
            r_s1_ch     <= r_ch;
            r_s1_rend   <= row_last;
            r_s1_fend   <= row_last && frame_last;
            r_s1_row0   <= (r_row_index == '0);
            r_s1_first  <= (r_byte_pos <= POS_W'(PSU_BYTES_PER_PIXEL));
            r_s1_addr   <= rd_addr;
        end
    end

    // prior-row store
    logic [7:0] ram_rdata;
    logic [7:0] val;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (ROW_STORE)
    ) u_prior_row (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (val),
        .i_re    (pix_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // neighbor bytes: a from rebuilt bytes, c from prior-row bytes, three back
    logic [23:0] r_left;
    logic [23:0] r_upper;
    t_pred_in    pred_in;
    logic        bad;

    always_comb begin
        pred_in.filter = r_s1_filter;
        pred_in.x      = r_s1_x;
        pred_in.b      = r_s1_row0 ? 8'd0 : ram_rdata;
        pred_in.a      = r_s1_first ? 8'd0 : r_left[23:16];
        pred_in.c      = r_s1_first ? 8'd0 : r_upper[23:16];
    end

    psu_predict u_predict (
        .i_pred  (pred_in),
        .o_value (val),
        .o_bad   (bad)
    );

    // the stage moves on when the output register is free or being emptied
    assign s1_adv = r_s1_valid && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_upper <= '0;
        end else if (s1_adv) begin
            r_left  <= {r_left[15:0], val};
            r_upper <= {r_upper[15:0], pred_in.b};
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_pixel_byte <= val;
            o_channel    <= r_s1_ch;
            o_row_end    <= r_s1_rend;
            o_frame_end  <= r_s1_fend;
            o_bad_filter <= bad;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    `PSU_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_out_valid && i_out_stall, !s1_adv)
    `PSU_ASSERT_NEXT(a_pix_loads_stage, i_clk, i_rst_n, pix_acc, r_s1_valid)
    `PSU_ASSERT_NEXT(a_frame_wraps, i_clk, i_rst_n, pix_acc && row_last && frame_last, r_row_index == '0 && r_byte_pos == '0)
    `PSU_ASSERT_NOW(a_frame_end_on_row_end, i_clk, i_rst_n, r_out_valid && o_frame_end, o_row_end)

endmodule
